### rtl/core/rei_pkg.sv
`default_nettype none

package rei_pkg;

    localparam int WORD_BITS      = 32;
    localparam int FRAC_BITS      = 16;
    localparam int CFG_INDEX_BITS = 3;

    localparam logic [CFG_INDEX_BITS-1:0] REG_CENTRE_X    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CENTRE_Y    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CENTRE_Z    = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SEMI_AXIS_X = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SEMI_AXIS_Y = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SEMI_AXIS_Z = 3'd5;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] start_x;
        logic signed [WORD_BITS-1:0] start_y;
        logic signed [WORD_BITS-1:0] start_z;
        logic signed [WORD_BITS-1:0] dir_x;
        logic signed [WORD_BITS-1:0] dir_y;
        logic signed [WORD_BITS-1:0] dir_z;
    } ray_t;

    typedef struct packed {
        logic                        hit_found;
        logic        [WORD_BITS-2:0] hit_distance;
        logic signed [WORD_BITS-1:0] point_x;
        logic signed [WORD_BITS-1:0] point_y;
        logic signed [WORD_BITS-1:0] point_z;
        logic signed [WORD_BITS-1:0] normal_x;
        logic signed [WORD_BITS-1:0] normal_y;
        logic signed [WORD_BITS-1:0] normal_z;
    } hit_t;

endpackage

`default_nettype wire

### rtl/core/rei_div.sv
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage.
// quo = floor(num * 2^FRAC_BITS / den); quo = 2^QB when that reaches 2^QB.
module rei_div #(
    parameter int LANES = 1,
    parameter int NB    = 33,
    parameter int DB    = 31,
    parameter int QB    = 31,
    parameter int SBW   = 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [LANES-1:0][NB-1:0]   num,
    input  logic [LANES-1:0][DB-1:0]   den,
    input  logic [SBW-1:0]             in_side,
    output logic                       out_valid,
    output logic [LANES-1:0][QB:0]     quo,
    output logic [SBW-1:0]             out_side
);
    import rei_pkg::*;

    localparam int XW = NB + FRAC_BITS;
    localparam int CW = ((XW > DB + QB) ? XW : DB + QB) + 1;

    logic [QB:0]                     v_reg;
    logic [LANES-1:0][CW-1:0]        rem_reg  [QB];
    logic [LANES-1:0][DB-1:0]        den_reg  [QB];
    logic [LANES-1:0][QB-1:0]        q_reg    [QB+1];
    logic [LANES-1:0]                ovf_reg  [QB+1];
    logic [SBW-1:0]                  side_reg [QB+1];

    logic [LANES-1:0][CW-1:0]        rem0_next;
    logic [LANES-1:0]                ovf0_next;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            rem0_next[l] = CW'({num[l], {FRAC_BITS{1'b0}}});
            ovf0_next[l] = rem0_next[l] >= (CW'(den[l]) << QB);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[QB-1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= rem0_next;
            den_reg[0]  <= den;
            q_reg[0]    <= '0;
            ovf_reg[0]  <= ovf0_next;
            side_reg[0] <= in_side;
        end
    end

    for (genvar j = 1; j <= QB; j++)
    begin : g_step
        localparam int K = QB - j;
        logic [LANES-1:0][CW-1:0] trial;
        logic [LANES-1:0][CW-1:0] rem_next;
        logic [LANES-1:0][QB-1:0] q_next;

        always_comb
        begin
            for (int l = 0; l < LANES; l++)
            begin
                trial[l]    = CW'(den_reg[j-1][l]) << K;
                rem_next[l] = rem_reg[j-1][l];
                q_next[l]   = q_reg[j-1][l];
                if (rem_reg[j-1][l] >= trial[l])
                begin
                    rem_next[l]  = rem_reg[j-1][l] - trial[l];
                    q_next[l][K] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[j]    <= q_next;
                ovf_reg[j]  <= ovf_reg[j-1];
                side_reg[j] <= side_reg[j-1];
            end
        end

        if (j < QB)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[j] <= rem_next;
                    den_reg[j] <= den_reg[j-1];
                end
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
            quo[l] = ovf_reg[QB][l] ? {1'b1, {QB{1'b0}}} : {1'b0, q_reg[QB][l]};
    end

    assign out_valid = v_reg[QB];
    assign out_side  = side_reg[QB];

endmodule

`default_nettype wire

### rtl/core/rei_sqrt.sv
`default_nettype none

// Pipelined floor square root, one root bit per stage.
module rei_sqrt #(
    parameter int DW  = 126,
    parameter int SBW = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [DW-1:0]     rad,
    input  logic [SBW-1:0]    in_side,
    output logic              out_valid,
    output logic [DW/2-1:0]   root,
    output logic [SBW-1:0]    out_side
);
    localparam int SW = DW / 2;

    logic [SW:0]     v_reg;
    logic [DW-1:0]   rem_reg  [SW];
    logic [SW-1:0]   s_reg    [SW+1];
    logic [SBW-1:0]  side_reg [SW+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[SW-1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= rad;
            s_reg[0]    <= '0;
            side_reg[0] <= in_side;
        end
    end

    for (genvar j = 1; j <= SW; j++)
    begin : g_step
        localparam int B = SW - j;
        logic [DW-1:0] trial;
        logic [DW-1:0] rem_next;
        logic [SW-1:0] s_next;

        // (s + 2^B)^2 - s^2 = s*2^(B+1) + 2^(2B); s has no bits at or below B
        always_comb
        begin
            trial    = (DW'(s_reg[j-1]) << (B + 1)) | (DW'(1'b1) << (2 * B));
            rem_next = rem_reg[j-1];
            s_next   = s_reg[j-1];
            if (rem_reg[j-1] >= trial)
            begin
                rem_next  = rem_reg[j-1] - trial;
                s_next[B] = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                s_reg[j]    <= s_next;
                side_reg[j] <= side_reg[j-1];
            end
        end

        if (j < SW)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                    rem_reg[j] <= rem_next;
            end
        end
    end

    assign out_valid = v_reg[SW];
    assign root      = s_reg[SW];
    assign out_side  = side_reg[SW];

endmodule

`default_nettype wire

### rtl/core/ray_ellipsoid_intersect.sv
`default_nettype none

// word     direction  handshake               payload
// ray      in         ray_valid / ray_ready   rei_pkg::ray_t
// hit      out        hit_valid / hit_ready   rei_pkg::hit_t
// cfg      in         cfg_write               cfg_index, cfg_data
//
// One ray enters per cycle while the output buffer is not full.
// The path runs through the three pipelined dividers and the 63-stage
// square root pipeline. All stages move together; a 2-word output buffer lets
// the pipe keep taking rays while one result waits, and stops it when full.
// Reset clears valid bits and restores centre 0, semi-axes 1.0.
module ray_ellipsoid_intersect (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                ray_valid,
    output logic                                ray_ready,
    input  rei_pkg::ray_t                       ray,
    output logic                                hit_valid,
    input  logic                                hit_ready,
    output rei_pkg::hit_t                       hit,
    input  logic                                cfg_write,
    input  logic [rei_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [rei_pkg::WORD_BITS-1:0]       cfg_data
);
    import rei_pkg::*;

    localparam int W    = WORD_BITS;
    localparam int F    = FRAC_BITS;
    localparam int UW   = W - 1;        // scaled component magnitude
    localparam int HW   = 2 * W - 2;    // a, |h|, |c|
    localparam int HALF = HW / 2;
    localparam int DW   = 2 * HW + 2;   // discriminant
    localparam int SW   = DW / 2;       // root
    localparam int NUMW = SW + 1;
    localparam int PW   = 2 * W - F + 1;

    localparam logic [W-1:0]  SCALED = W'(1) << (W - 2);
    localparam logic [W-2:0]  SMAX   = {(W-1){1'b1}};
    localparam logic signed [PW-1:0] P_MAX = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [PW-1:0] P_MIN = {{(PW-W+1){1'b1}}, {(W-1){1'b0}}};

    typedef struct packed {
        ray_t       ray;
        logic [5:0] neg;
    } s1_t;

    typedef struct packed {
        ray_t               ray;
        logic [HW-1:0]      a;
        logic signed [HW:0] h;
        logic               nohit;
    } s2_t;

    typedef struct packed {
        ray_t ray;
        logic found;
    } s3_t;

    typedef struct packed {
        logic [2:0][W-1:0] p;
        logic [W-2:0]      t;
        logic              found;
        logic [2:0]        neg;
    } s4_t;

    // ---------------- configuration ----------------
    logic signed [W-1:0] centre_reg [3];
    logic [W-2:0]        semi_reg   [3];
    logic [W-2:0]        sa_eff     [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                centre_reg[i] <= '0;
                semi_reg[i]   <= (W-1)'(1) << F;
            end
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_CENTRE_X:    centre_reg[0] <= cfg_data;
                REG_CENTRE_Y:    centre_reg[1] <= cfg_data;
                REG_CENTRE_Z:    centre_reg[2] <= cfg_data;
                REG_SEMI_AXIS_X: semi_reg[0]   <= cfg_data[W-2:0];
                REG_SEMI_AXIS_Y: semi_reg[1]   <= cfg_data[W-2:0];
                REG_SEMI_AXIS_Z: semi_reg[2]   <= cfg_data[W-2:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            sa_eff[i] = (semi_reg[i] == '0) ? (W-1)'(1) : semi_reg[i];
    end

    logic pipe_en;

    // ---------------- scale by semi-axes ----------------
    logic signed [W-1:0]      ray_st [3];
    logic signed [W-1:0]      ray_dr [3];
    logic signed [W:0]        d1_diff [3];
    logic [5:0][W:0]          d1_num;
    logic [5:0][W-2:0]        d1_den;
    s1_t                      d1_in_side;
    logic                     d1_valid;
    logic [5:0][W-1:0]        d1_quo;
    s1_t                      d1_side;

    assign ray_st[0] = ray.start_x;
    assign ray_st[1] = ray.start_y;
    assign ray_st[2] = ray.start_z;
    assign ray_dr[0] = ray.dir_x;
    assign ray_dr[1] = ray.dir_y;
    assign ray_dr[2] = ray.dir_z;

    always_comb
    begin
        d1_in_side.ray = ray;
        for (int i = 0; i < 3; i++)
        begin
            d1_diff[i]           = (W+1)'(ray_st[i]) - (W+1)'(centre_reg[i]);
            d1_in_side.neg[i]    = ray_dr[i][W-1];
            d1_in_side.neg[3+i]  = d1_diff[i][W];
            d1_num[i]   = ray_dr[i][W-1] ? (W+1)'(-(W+1)'(ray_dr[i])) : (W+1)'(ray_dr[i]);
            d1_num[3+i] = d1_diff[i][W] ? (W+1)'(-d1_diff[i]) : (W+1)'(d1_diff[i]);
            d1_den[i]   = sa_eff[i];
            d1_den[3+i] = sa_eff[i];
        end
    end

    rei_div #(
        .LANES (6),
        .NB    (W + 1),
        .DB    (W - 1),
        .QB    (W - 1),
        .SBW   ($bits(s1_t))
    ) u_div_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (ray_valid),
        .num       (d1_num),
        .den       (d1_den),
        .in_side   (d1_in_side),
        .out_valid (d1_valid),
        .quo       (d1_quo),
        .out_side  (d1_side)
    );

    // ---------------- quadratic coefficients ----------------
    logic [UW-1:0]     u_sat [6];
    logic [2*UW-1:0]   uu_next [3];
    logic [2*UW-1:0]   uw_next [3];
    logic [2*UW-1:0]   ww_next [3];

    logic              m1_valid_reg;
    ray_t              m1_ray_reg;
    logic [2*UW-1:0]   uu_reg [3];
    logic [2*UW-1:0]   uw_reg [3];
    logic [2*UW-1:0]   ww_reg [3];
    logic [2:0]        uw_neg_reg;

    always_comb
    begin
        for (int i = 0; i < 6; i++)
            u_sat[i] = (d1_quo[i] > SCALED) ? SCALED[UW-1:0] : d1_quo[i][UW-1:0];
        for (int i = 0; i < 3; i++)
        begin
            uu_next[i] = u_sat[i] * u_sat[i];
            uw_next[i] = u_sat[i] * u_sat[3+i];
            ww_next[i] = u_sat[3+i] * u_sat[3+i];
        end
    end

    logic              m2_valid_reg;
    ray_t              m2_ray_reg;
    logic [HW-1:0]     a_reg;
    logic signed [HW:0] h_reg;
    logic signed [HW:0] c_reg;
    logic [HW-1:0]     a_next;
    logic signed [HW:0] h_next;
    logic signed [HW:0] c_next;

    always_comb
    begin
        a_next = HW'(uu_reg[0]) + HW'(uu_reg[1]) + HW'(uu_reg[2]);
        h_next = '0;
        c_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            h_next = h_next + (uw_neg_reg[i] ? -(HW+1)'(uw_reg[i]) : (HW+1)'(uw_reg[i]));
            c_next = c_next + (HW+1)'(ww_reg[i]);
        end
        c_next = c_next - ((HW+1)'(1) << (2 * F));
    end

    // split h^2 and a*c into half-width partial products
    logic [HW:0]       hm_full;
    logic [HW:0]       cm_full;
    logic [HW-1:0]     hm;
    logic [HW-1:0]     cm;

    logic              m3_valid_reg;
    ray_t              m3_ray_reg;
    logic [HW-1:0]     m3_a_reg;
    logic signed [HW:0] m3_h_reg;
    logic              m3_zero_a_reg;
    logic              m3_c_le0_reg;
    logic [HW-1:0]     hh00_reg, hh01_reg, hh11_reg;
    logic [HW-1:0]     ac00_reg, ac01_reg, ac10_reg, ac11_reg;

    always_comb
    begin
        hm_full = h_reg[HW] ? -h_reg : h_reg;
        cm_full = c_reg[HW] ? -c_reg : c_reg;
        hm      = hm_full[HW-1:0];
        cm      = cm_full[HW-1:0];
    end

    logic              m4_valid_reg;
    ray_t              m4_ray_reg;
    logic [HW-1:0]     m4_a_reg;
    logic signed [HW:0] m4_h_reg;
    logic              m4_zero_a_reg;
    logic              m4_c_le0_reg;
    logic [HW-1:0]     m4_hh00_reg, m4_hh11_reg, m4_ac00_reg, m4_ac11_reg;
    logic [HW:0]       h2mid_reg, acmid_reg;

    logic              m5_valid_reg;
    ray_t              m5_ray_reg;
    logic [HW-1:0]     m5_a_reg;
    logic signed [HW:0] m5_h_reg;
    logic              m5_zero_a_reg;
    logic              m5_c_le0_reg;
    logic [DW-1:0]     h2_reg, ac_reg;

    logic              m6_valid_reg;
    s2_t               m6_side_reg;
    logic [DW-1:0]     disc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg <= 1'b0;
            m2_valid_reg <= 1'b0;
            m3_valid_reg <= 1'b0;
            m4_valid_reg <= 1'b0;
            m5_valid_reg <= 1'b0;
            m6_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            m1_valid_reg <= d1_valid;
            m2_valid_reg <= m1_valid_reg;
            m3_valid_reg <= m2_valid_reg;
            m4_valid_reg <= m3_valid_reg;
            m5_valid_reg <= m4_valid_reg;
            m6_valid_reg <= m5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            m1_ray_reg <= d1_side.ray;
            for (int i = 0; i < 3; i++)
            begin
                uu_reg[i]     <= uu_next[i];
                uw_reg[i]     <= uw_next[i];
                ww_reg[i]     <= ww_next[i];
                uw_neg_reg[i] <= d1_side.neg[i] ^ d1_side.neg[3+i];
            end

            m2_ray_reg <= m1_ray_reg;
            a_reg      <= a_next;
            h_reg      <= h_next;
            c_reg      <= c_next;

            m3_ray_reg    <= m2_ray_reg;
            m3_a_reg      <= a_reg;
            m3_h_reg      <= h_reg;
            m3_zero_a_reg <= (a_reg == '0);
            m3_c_le0_reg  <= c_reg[HW] || (c_reg == '0);
            hh00_reg      <= hm[HALF-1:0] * hm[HALF-1:0];
            hh01_reg      <= hm[HALF-1:0] * hm[HW-1:HALF];
            hh11_reg      <= hm[HW-1:HALF] * hm[HW-1:HALF];
            ac00_reg      <= a_reg[HALF-1:0] * cm[HALF-1:0];
            ac01_reg      <= a_reg[HALF-1:0] * cm[HW-1:HALF];
            ac10_reg      <= a_reg[HW-1:HALF] * cm[HALF-1:0];
            ac11_reg      <= a_reg[HW-1:HALF] * cm[HW-1:HALF];

            m4_ray_reg    <= m3_ray_reg;
            m4_a_reg      <= m3_a_reg;
            m4_h_reg      <= m3_h_reg;
            m4_zero_a_reg <= m3_zero_a_reg;
            m4_c_le0_reg  <= m3_c_le0_reg;
            m4_hh00_reg   <= hh00_reg;
            m4_hh11_reg   <= hh11_reg;
            m4_ac00_reg   <= ac00_reg;
            m4_ac11_reg   <= ac11_reg;
            h2mid_reg     <= {hh01_reg, 1'b0};
            acmid_reg     <= (HW+1)'(ac01_reg) + (HW+1)'(ac10_reg);

            m5_ray_reg    <= m4_ray_reg;
            m5_a_reg      <= m4_a_reg;
            m5_h_reg      <= m4_h_reg;
            m5_zero_a_reg <= m4_zero_a_reg;
            m5_c_le0_reg  <= m4_c_le0_reg;
            h2_reg        <= DW'({m4_hh11_reg, m4_hh00_reg}) + (DW'(h2mid_reg) << HALF);
            ac_reg        <= DW'({m4_ac11_reg, m4_ac00_reg}) + (DW'(acmid_reg) << HALF);

            // c <= 0 adds |a c|; otherwise a negative discriminant is a miss; a == 0 is a miss
            m6_side_reg.ray   <= m5_ray_reg;
            m6_side_reg.a     <= m5_a_reg;
            m6_side_reg.h     <= m5_h_reg;
            m6_side_reg.nohit <= m5_zero_a_reg || (!m5_c_le0_reg && (h2_reg < ac_reg));
            disc_reg          <= m5_c_le0_reg ? (h2_reg + ac_reg) : (h2_reg - ac_reg);
        end
    end

    // ---------------- square root ----------------
    logic          sq_valid;
    logic [SW-1:0] sq_root;
    s2_t           sq_side;

    rei_sqrt #(
        .DW  (DW),
        .SBW ($bits(s2_t))
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (m6_valid_reg),
        .rad       (disc_reg),
        .in_side   (m6_side_reg),
        .out_valid (sq_valid),
        .root      (sq_root),
        .out_side  (sq_side)
    );

    // ---------------- root choice ----------------
    logic [HW:0]     r_hm_full;
    logic [HW-1:0]   r_hm;
    logic            r_found_next;
    logic [NUMW-1:0] r_num_next;

    always_comb
    begin
        r_hm_full    = sq_side.h[HW] ? -sq_side.h : sq_side.h;
        r_hm         = r_hm_full[HW-1:0];
        r_found_next = !sq_side.nohit &&
                       ($signed({1'b0, sq_root}) > $signed({sq_side.h[HW], sq_side.h}));
        if (sq_side.h[HW] && (NUMW'(r_hm) > NUMW'(sq_root)))
            r_num_next = NUMW'(r_hm) - NUMW'(sq_root);
        else if (sq_side.h[HW])
            r_num_next = NUMW'(sq_root) + NUMW'(r_hm);
        else
            r_num_next = NUMW'(sq_root) - NUMW'(sq_side.h[HW-1:0]);
    end

    logic              r_valid_reg;
    logic [NUMW-1:0]   r_num_reg;
    logic [HW-1:0]     r_a_reg;
    s3_t               r_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            r_valid_reg <= 1'b0;
        else if (pipe_en)
            r_valid_reg <= sq_valid;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            r_num_reg        <= r_num_next;
            r_a_reg          <= sq_side.a;
            r_side_reg.ray   <= sq_side.ray;
            r_side_reg.found <= r_found_next;
        end
    end

    logic          d2_valid;
    logic [0:0][W-1:0] d2_quo;
    s3_t           d2_side;

    rei_div #(
        .LANES (1),
        .NB    (NUMW),
        .DB    (HW),
        .QB    (W - 1),
        .SBW   ($bits(s3_t))
    ) u_div_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (r_valid_reg),
        .num       (r_num_reg),
        .den       (r_a_reg),
        .in_side   (r_side_reg),
        .out_valid (d2_valid),
        .quo       (d2_quo),
        .out_side  (d2_side)
    );

    // ---------------- hit point ----------------
    logic [W-2:0]        t_sat;
    logic signed [W-1:0] d2_dr [3];
    logic signed [W-1:0] d2_st [3];

    assign t_sat    = d2_quo[0][W-1] ? SMAX : d2_quo[0][W-2:0];
    assign d2_st[0] = d2_side.ray.start_x;
    assign d2_st[1] = d2_side.ray.start_y;
    assign d2_st[2] = d2_side.ray.start_z;
    assign d2_dr[0] = d2_side.ray.dir_x;
    assign d2_dr[1] = d2_side.ray.dir_y;
    assign d2_dr[2] = d2_side.ray.dir_z;

    logic                p1_valid_reg;
    logic [2*W-2:0]      p1_prod_reg [3];
    logic signed [W-1:0] p1_st_reg [3];
    logic [2:0]          p1_neg_reg;
    logic [W-2:0]        p1_t_reg;
    logic                p1_found_reg;
    logic [W-1:0]        dr_mag [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            dr_mag[i] = d2_dr[i][W-1] ? W'(-d2_dr[i]) : W'(d2_dr[i]);
    end

    logic                p2_valid_reg;
    logic [W-1:0]        p2_p_reg [3];
    logic [W-2:0]        p2_t_reg;
    logic                p2_found_reg;
    logic signed [PW-1:0] p_wide [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            p_wide[i] = PW'(p1_st_reg[i]) +
                        (p1_neg_reg[i] ? -PW'(p1_prod_reg[i] >> F) : PW'(p1_prod_reg[i] >> F));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            p1_valid_reg <= d2_valid;
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                p1_prod_reg[i] <= dr_mag[i] * t_sat;
                p1_st_reg[i]   <= d2_st[i];
                p1_neg_reg[i]  <= d2_dr[i][W-1];
                if (p_wide[i] > P_MAX)
                    p2_p_reg[i] <= P_MAX[W-1:0];
                else if (p_wide[i] < P_MIN)
                    p2_p_reg[i] <= P_MIN[W-1:0];
                else
                    p2_p_reg[i] <= p_wide[i][W-1:0];
            end
            p1_t_reg     <= t_sat;
            p1_found_reg <= d2_side.found;
            p2_t_reg     <= p1_t_reg;
            p2_found_reg <= p1_found_reg;
        end
    end

    // ---------------- normal ----------------
    logic signed [W:0]   d3_diff [3];
    logic [2:0][W:0]     d3_num;
    logic [2:0][W-2:0]   d3_den;
    s4_t                 d3_in_side;
    logic                d3_valid;
    logic [2:0][W:0]     d3_quo;
    s4_t                 d3_side;

    always_comb
    begin
        d3_in_side.t     = p2_t_reg;
        d3_in_side.found = p2_found_reg;
        for (int i = 0; i < 3; i++)
        begin
            d3_diff[i]          = (W+1)'($signed(p2_p_reg[i])) - (W+1)'(centre_reg[i]);
            d3_in_side.p[i]     = p2_p_reg[i];
            d3_in_side.neg[i]   = d3_diff[i][W];
            d3_num[i] = d3_diff[i][W] ? (W+1)'(-d3_diff[i]) : (W+1)'(d3_diff[i]);
            d3_den[i] = sa_eff[i];
        end
    end

    rei_div #(
        .LANES (3),
        .NB    (W + 1),
        .DB    (W - 1),
        .QB    (W),
        .SBW   ($bits(s4_t))
    ) u_div_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (p2_valid_reg),
        .num       (d3_num),
        .den       (d3_den),
        .in_side   (d3_in_side),
        .out_valid (d3_valid),
        .quo       (d3_quo),
        .out_side  (d3_side)
    );

    localparam logic [W:0] NEG_LIM = (W+1)'(1) << (W - 1);
    localparam logic [W:0] POS_LIM = NEG_LIM - (W+1)'(1);

    logic [W:0]   n_lim [3];
    logic [W-1:0] n_val [3];
    hit_t         word_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (d3_side.neg[i])
                n_lim[i] = (d3_quo[i] > NEG_LIM) ? NEG_LIM : d3_quo[i];
            else
                n_lim[i] = (d3_quo[i] > POS_LIM) ? POS_LIM : d3_quo[i];
            n_val[i] = d3_side.neg[i] ? W'(-n_lim[i]) : n_lim[i][W-1:0];
        end
        word_next = '0;
        if (d3_side.found)
        begin
            word_next.hit_found    = 1'b1;
            word_next.hit_distance = d3_side.t;
            word_next.point_x      = d3_side.p[0];
            word_next.point_y      = d3_side.p[1];
            word_next.point_z      = d3_side.p[2];
            word_next.normal_x     = n_val[0];
            word_next.normal_y     = n_val[1];
            word_next.normal_z     = n_val[2];
        end
    end

    // ---------------- output buffer ----------------
    hit_t       fifo_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       push, pop;

    assign pipe_en   = (cnt_reg != 2'd2);
    assign ray_ready = pipe_en;
    assign push      = d3_valid && pipe_en;
    assign pop       = hit_valid && hit_ready;
    assign hit_valid = (cnt_reg != 2'd0);
    assign hit       = fifo_reg[rd_ptr_reg];
    assign cnt_next  = cnt_reg + {1'b0, push} - {1'b0, pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= word_next;
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("output buffer count out of range");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        hit_valid && !hit.hit_found |->
            hit.hit_distance == '0 && hit.point_x == '0 && hit.normal_x == '0)
        else $error("miss word carries nonzero fields");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !pipe_en |=> $stable(d3_valid))
        else $error("pipeline moved while stalled");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop && cnt_reg == 2'd1 |=> !ray_ready)
        else $error("buffer filled but input still ready");

endmodule

`default_nettype wire
